// ===== hdl/msm_pkg.sv =====
// Package for the shared-memory multiple-stack core.
// Defaults, field widths, opcode and status codes; no dependencies.
package msm_pkg;

    localparam int MEMORY_DEPTH_DEF = 16;
    localparam int STACKS_MAX_DEF   = 8;
    localparam int DATA_WIDTH_DEF   = 32;

    localparam int COUNT_RESET = 3;
    localparam int CFG_W       = 4;
    localparam int OPCODE_W    = 2;
    localparam int INDEX_W     = 3;
    localparam int ITEM_W      = 32;
    localparam int STATUS_W    = 2;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 32;

    localparam logic [OPCODE_W-1:0] OP_PUSH = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_POP  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_LIST = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_NONE = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD   = 2'd3;

endpackage

// ===== hdl/msm_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module msm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hdl/msm_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Computes the partition size; no dependencies.
module msm_div #(
    parameter int NUM_W = 5,
    parameter int DEN_W = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic [DEN_W:0]   trial;
    logic             fits;

    always_comb begin
        trial    = {rem_reg, quo_reg[NUM_W-1]};
        fits     = trial >= {1'b0, den};
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        run_next = run_reg;
        if (start) begin
            rem_next = '0;
            quo_next = num;
            cnt_next = CNT_W'(NUM_W);
            run_next = 1'b1;
        end else if (run_reg) begin
            rem_next = fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            run_next = cnt_reg != CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign busy = run_reg;
    assign quo  = quo_reg;

endmodule

// ===== hdl/multiple_stacks_shared_memory_core.sv =====
// Top level of the shared-memory multiple-stack core.
// Depends on msm_pkg, msm_ram and msm_div.
//
// Up to STACKS_MAX stacks share one element RAM of MEMORY_DEPTH entries, split
// into equal partitions of MEMORY_DEPTH/stack_count (the last stack takes the
// remainder). One item is handled at a time; s_tready is low while an item is
// in work. Push, a full or empty report and a bad stack index pass through
// S_ADDR and S_EXEC; pop adds the registered RAM read (S_RDW, S_RD), and a
// list repeats S_RDW and S_RD for each element. S_EXEC and S_RD wait while an
// earlier result is still unaccepted. Results are held in an output register,
// so the next item is taken while the last result waits. A stack_count write
// empties all stacks and runs the bit-serial partition divider, which blocks
// both channels until it is done; the same happens once after reset.
module multiple_stacks_shared_memory_core #(
    parameter int MEMORY_DEPTH = msm_pkg::MEMORY_DEPTH_DEF,
    parameter int STACKS_MAX   = msm_pkg::STACKS_MAX_DEF,
    parameter int DATA_WIDTH   = msm_pkg::DATA_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [msm_pkg::CFG_W-1:0]      cfg_data,   // stack_count
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [msm_pkg::S_TDATA_W-1:0]  s_tdata,    // stack_index[2:0], item_data[34:3]
    input  logic [msm_pkg::OPCODE_W-1:0]   s_tuser,    // opcode[1:0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [msm_pkg::M_TDATA_W-1:0]  m_tdata,    // out_data[31:0]
    output logic [msm_pkg::STATUS_W-1:0]   m_tuser,    // status[1:0]
    output logic                           m_tlast
);
    import msm_pkg::*;

    localparam int AW = $clog2(MEMORY_DEPTH);
    localparam int PW = $clog2(MEMORY_DEPTH + 1);
    localparam int CW = $clog2(STACKS_MAX + 1);
    localparam int IW = (STACKS_MAX > 1) ? $clog2(STACKS_MAX) : 1;
    localparam int SW = (DATA_WIDTH < ITEM_W) ? DATA_WIDTH : ITEM_W;
    localparam int N_RESET = (COUNT_RESET > STACKS_MAX) ? STACKS_MAX : COUNT_RESET;

    typedef enum logic [2:0] {
        S_INIT, S_DIV, S_IDLE, S_ADDR, S_EXEC, S_RDW, S_RD
    } state_t;

    state_t                state_reg, state_next;
    logic [CW-1:0]         n_reg, n_next;
    logic [PW-1:0]         part_reg, part_next;
    logic [PW-1:0]         cnt_reg [STACKS_MAX];
    logic [PW-1:0]         cnt_next [STACKS_MAX];
    logic [OPCODE_W-1:0]   op_reg, op_next;
    logic [INDEX_W-1:0]    idx_reg, idx_next;
    logic [SW-1:0]         data_reg, data_next;
    logic [PW-1:0]         lo_reg, lo_next;
    logic [PW-1:0]         hi_reg, hi_next;
    logic [PW-1:0]         top_reg, top_next;
    logic                  bad_reg, bad_next;
    logic [AW-1:0]         addr_reg, addr_next;
    logic                  mv_reg, mv_next;
    logic [SW-1:0]         md_reg, md_next;
    logic [STATUS_W-1:0]   ms_reg, ms_next;
    logic                  ml_reg, ml_next;

    logic                  div_start, div_busy;
    logic [PW-1:0]         div_quo;
    logic                  ram_we;
    logic [SW-1:0]         ram_q;
    logic [PW+INDEX_W-1:0] prod;
    logic [IW-1:0]         sel;
    logic                  out_free, is_last_stack, list_end;
    logic [CW-1:0]         n_clamp;

    msm_div #(.NUM_W(PW), .DEN_W(CW)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (PW'(MEMORY_DEPTH)),
        .den     (n_reg),
        .busy    (div_busy),
        .quo     (div_quo)
    );

    msm_ram #(.WIDTH(SW), .DEPTH(MEMORY_DEPTH)) u_ram (
        .aclk    (aclk),
        .we      (ram_we),
        .wr_addr (top_reg[AW-1:0]),
        .wr_data (data_reg),
        .rd_addr (addr_reg),
        .rd_data (ram_q)
    );

    assign cfg_ready = state_reg == S_IDLE;
    assign s_tready  = (state_reg == S_IDLE) && !cfg_valid;
    assign out_free  = !mv_reg || m_tready;
    assign sel       = IW'(idx_reg);
    assign prod      = part_reg * idx_reg;
    assign is_last_stack = 32'(idx_reg) == 32'(n_reg) - 1;
    assign list_end  = (op_reg == OP_POP) || (PW'(addr_reg) == lo_reg);

    always_comb begin
        if (cfg_data == '0) begin
            n_clamp = CW'(1);
        end else if (32'(cfg_data) > STACKS_MAX) begin
            n_clamp = CW'(STACKS_MAX);
        end else begin
            n_clamp = CW'(cfg_data);
        end
    end

    always_comb begin
        state_next = state_reg;
        n_next     = n_reg;
        part_next  = part_reg;
        cnt_next   = cnt_reg;
        op_next    = op_reg;
        idx_next   = idx_reg;
        data_next  = data_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        top_next   = top_reg;
        bad_next   = bad_reg;
        addr_next  = addr_reg;
        mv_next    = mv_reg && !m_tready;
        md_next    = md_reg;
        ms_next    = ms_reg;
        ml_next    = ml_reg;
        div_start  = 1'b0;
        ram_we     = 1'b0;

        unique case (state_reg)
            S_INIT: begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV: begin
                if (!div_busy) begin
                    part_next  = div_quo;
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (cfg_valid) begin
                    n_next = n_clamp;
                    for (int j = 0; j < STACKS_MAX; j++) begin
                        cnt_next[j] = '0;
                    end
                    state_next = S_INIT;
                end else if (s_tvalid && s_tuser != OP_NONE) begin
                    op_next    = s_tuser;
                    idx_next   = s_tdata[INDEX_W-1:0];
                    data_next  = s_tdata[INDEX_W +: SW];
                    state_next = S_ADDR;
                end
            end
            S_ADDR: begin
                bad_next   = 32'(idx_reg) >= 32'(n_reg);
                lo_next    = prod[PW-1:0];
                top_next   = prod[PW-1:0] + cnt_reg[sel];
                hi_next    = is_last_stack ? PW'(MEMORY_DEPTH) : prod[PW-1:0] + part_reg;
                state_next = S_EXEC;
            end
            S_EXEC: begin
                if (out_free) begin
                    mv_next = 1'b1;
                    md_next = '0;
                    ml_next = 1'b1;
                    ms_next = ST_OK;
                    state_next = S_IDLE;
                    if (bad_reg) begin
                        ms_next = ST_BAD;
                    end else if (op_reg == OP_PUSH) begin
                        if (top_reg >= hi_reg) begin
                            ms_next = ST_FULL;
                        end else begin
                            ram_we        = 1'b1;
                            cnt_next[sel] = cnt_reg[sel] + 1'b1;
                        end
                    end else if (top_reg == lo_reg) begin
                        ms_next = ST_EMPTY;
                    end else begin
                        mv_next   = 1'b0;
                        addr_next = AW'(top_reg - 1'b1);
                        if (op_reg == OP_POP) begin
                            cnt_next[sel] = cnt_reg[sel] - 1'b1;
                        end
                        state_next = S_RDW;
                    end
                end
            end
            S_RDW: begin
                state_next = S_RD;
            end
            S_RD: begin
                if (out_free) begin
                    mv_next = 1'b1;
                    md_next = ram_q;
                    ms_next = ST_OK;
                    ml_next = list_end;
                    if (list_end) begin
                        state_next = S_IDLE;
                    end else begin
                        addr_next  = addr_reg - 1'b1;
                        state_next = S_RDW;
                    end
                end
            end
            default: state_next = S_INIT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            n_reg     <= CW'(N_RESET);
            mv_reg    <= 1'b0;
            for (int j = 0; j < STACKS_MAX; j++) begin
                cnt_reg[j] <= '0;
            end
        end else begin
            state_reg <= state_next;
            n_reg     <= n_next;
            mv_reg    <= mv_next;
            cnt_reg   <= cnt_next;
        end
        part_reg <= part_next;
        op_reg   <= op_next;
        idx_reg  <= idx_next;
        data_reg <= data_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        top_reg  <= top_next;
        bad_reg  <= bad_next;
        addr_reg <= addr_next;
        md_reg   <= md_next;
        ms_reg   <= ms_next;
        ml_reg   <= ml_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = M_TDATA_W'(md_reg);
    assign m_tuser  = ms_reg;
    assign m_tlast  = ml_reg;

`ifndef SYNTHESIS
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser != OP_NONE |=> !s_tready)
        else $error("new item taken while one is in work");

    a_cfg_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready |=> !s_tready && !cfg_ready)
        else $error("channels open during partition recompute");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_OK |-> m_tdata == '0 && m_tlast)
        else $error("error result carries data or is not last");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable({m_tdata, m_tuser, m_tlast}))
        else $error("result changed while stalled");
`endif

endmodule

// ===== test/multiple_stacks_shared_memory_core_tb.sv =====
// Self-checking testbench for multiple_stacks_shared_memory_core.
// It checks push, pop, list, full, empty and bad-index results against a predictor
// of the shared stack memory, over several stack_count settings. Depends on msm_pkg.
module multiple_stacks_shared_memory_core_tb;

    import msm_pkg::*;

    localparam int MEM_DEPTH  = MEMORY_DEPTH_DEF;
    localparam int STACK_MAX  = STACKS_MAX_DEF;
    localparam int LONG_HOLD  = 300;
    localparam int DRAIN_WAIT = 12;
    localparam int SETTLE     = 40;

    typedef struct packed {
        logic [ITEM_W-1:0]   data;
        logic [STATUS_W-1:0] status;
        logic                last;
    } stack_result_t;

    class stack_scoreboard;
        logic [ITEM_W-1:0] element_mem [MEM_DEPTH];
        logic [4:0]        top_ptr     [STACK_MAX];
        logic [4:0]        bound       [STACK_MAX+1];
        logic [3:0]        count;
        stack_result_t     expected_results [$];
        int                errors;
        int                items_in;
        int                results_out;

        function new();
            foreach (element_mem[i]) element_mem[i] = '0;
            errors = 0;
            items_in = 0;
            results_out = 0;
            load_count(4'(COUNT_RESET));
        endfunction

        // A stack_count write also empties every stack.
        function void load_count(logic [3:0] value);
            int n;
            int part;
            n = (value == 0) ? 1 : (value > STACK_MAX) ? STACK_MAX : value;
            count = 4'(n);
            part = MEM_DEPTH / n;
            for (int j = 0; j <= STACK_MAX; j++) begin
                bound[j] = (j < n) ? 5'(part * j) : 5'(MEM_DEPTH);
                if (j < STACK_MAX) top_ptr[j] = bound[j];
            end
        endfunction

        function void expect_result(logic [ITEM_W-1:0] d, logic [STATUS_W-1:0] s,
                                    logic l);
            stack_result_t r;
            r.data = d;
            r.status = s;
            r.last = l;
            expected_results.push_back(r);
        endfunction

        function void predict_item(logic [OPCODE_W-1:0] op, logic [INDEX_W-1:0] idx,
                                   logic [ITEM_W-1:0] value);
            logic [4:0] lo;
            logic [4:0] hi;
            logic [4:0] t;
            int a;
            items_in++;
            if (op == OP_NONE) return;
            if (idx >= count) begin
                expect_result('0, ST_BAD, 1'b1);
                return;
            end
            lo = bound[idx];
            hi = bound[idx+1];
            t  = top_ptr[idx];
            case (op)
                OP_PUSH: begin
                    if (t >= hi) begin
                        expect_result('0, ST_FULL, 1'b1);
                    end else begin
                        element_mem[t] = value;
                        top_ptr[idx] = t + 5'd1;
                        expect_result('0, ST_OK, 1'b1);
                    end
                end
                OP_POP: begin
                    if (t <= lo) begin
                        expect_result('0, ST_EMPTY, 1'b1);
                    end else begin
                        top_ptr[idx] = t - 5'd1;
                        expect_result(element_mem[t-1], ST_OK, 1'b1);
                    end
                end
                default: begin
                    if (t <= lo) begin
                        expect_result('0, ST_EMPTY, 1'b1);
                    end else begin
                        for (a = t; a > lo; a--)
                            expect_result(element_mem[a-1], ST_OK, (a - 1) == lo);
                    end
                end
            endcase
        endfunction

        function void check_result(logic [ITEM_W-1:0] d, logic [STATUS_W-1:0] s,
                                   logic l);
            stack_result_t r;
            results_out++;
            if (expected_results.size() == 0) begin
                $error("result with nothing expected: out_data %h status %0d last %0b",
                       d, s, l);
                errors++;
                return;
            end
            r = expected_results.pop_front();
            if (d !== r.data) begin
                $error("out_data: expected %h, actual %h", r.data, d);
                errors++;
            end
            if (s !== r.status) begin
                $error("status: expected %0d, actual %0d", r.status, s);
                errors++;
            end
            if (l !== r.last) begin
                $error("last: expected %0b, actual %0b", r.last, l);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_W-1:0]      cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;     // stack_index[2:0], item_data[34:3]
    logic [OPCODE_W-1:0]   s_tuser   = '0;     // opcode[1:0]
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;            // out_data[31:0]
    logic [STATUS_W-1:0]   m_tuser;            // status[1:0]
    logic                  m_tlast;

    stack_scoreboard board = new();
    int   burst_left   = 0;
    int   holds_asked  = 0;
    int   holds_done   = 0;
    int   hold_left    = 0;
    int   count_writes = 0;
    logic [8:0] stall_tick = '0;

    multiple_stacks_shared_memory_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #5 aclk = ~aclk;

    // Result side: check each transfer, stall on a rotating pattern, long hold on request.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata, m_tuser, m_tlast);
        stall_tick <= stall_tick + 9'd1;
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (holds_asked != holds_done) begin
            holds_done <= holds_done + 1;
            hold_left  <= LONG_HOLD;
            m_tready   <= 1'b0;
        end else begin
            case (stall_tick[8:7])
                2'd0: m_tready <= 1'b1;
                2'd1: m_tready <= 1'($urandom_range(0, 1));
                2'd2: m_tready <= (stall_tick[1:0] == 2'd0);
                default: m_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Called at a clock edge; returns at the edge of the transfer, tvalid still high.
    task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [INDEX_W-1:0] idx,
                             input logic [ITEM_W-1:0] value);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(S_TDATA_W-ITEM_W-INDEX_W){1'b0}}, value, idx};
        do @(posedge aclk); while (!s_tready);
        board.predict_item(op, idx, value);
    endtask

    task automatic offer(input logic [OPCODE_W-1:0] op, input logic [INDEX_W-1:0] idx,
                         input logic [ITEM_W-1:0] value);
        int gap;
        send_item(op, idx, value);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(0, 6);
            burst_left = $urandom_range(0, 10);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (board.expected_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_count(input logic [CFG_W-1:0] value);
        wait_drained();
        // an ignored opcode is dropped at the input and leaves nothing in work
        repeat (DRAIN_WAIT) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.load_count(value);
        count_writes++;
    endtask

    task automatic fill_and_list(input logic [INDEX_W-1:0] idx);
        int pushes;
        pushes = board.bound[idx+1] - board.top_ptr[idx] + 1;
        repeat (pushes) offer(OP_PUSH, idx, $urandom);
        offer(OP_LIST, idx, $urandom);
    endtask

    task automatic random_items(input int n);
        int pick;
        logic [INDEX_W-1:0] idx;
        repeat (n) begin
            pick = $urandom_range(0, 99);
            idx = INDEX_W'($urandom_range(0, board.count - 1));
            if (pick < 45) begin
                offer(OP_PUSH, idx, $urandom);
            end else if (pick < 70) begin
                offer(OP_POP, idx, $urandom);
            end else if (pick < 85) begin
                offer(OP_LIST, idx, $urandom);
            end else if (pick < 93 && board.count < STACK_MAX) begin
                offer(OPCODE_W'($urandom_range(0, 2)),
                      INDEX_W'($urandom_range(board.count, STACK_MAX - 1)), $urandom);
            end else begin
                offer(OP_NONE, INDEX_W'($urandom_range(0, 7)), $urandom);
            end
        end
    endtask

    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        logic [CFG_W-1:0] counts [8];
        counts = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd5, 4'd2, 4'd7, 4'd3};
        counts[7] = CFG_W'($urandom_range(0, 15));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset split 5/5/6
        offer(OP_PUSH, 3'd0, 32'h0000_0000);
        offer(OP_PUSH, 3'd0, 32'hFFFF_FFFF);
        offer(OP_PUSH, 3'd1, 32'hA5A5_A5A5);
        offer(OP_POP,  3'd0, 32'hFFFF_FFFF);
        offer(OP_POP,  3'd0, 32'h0);
        offer(OP_POP,  3'd0, 32'h0);
        offer(OP_LIST, 3'd2, 32'h0);
        offer(OP_LIST, 3'd1, 32'h0);
        offer(OP_PUSH, 3'd3, 32'h1234_5678);
        offer(OP_POP,  3'd7, 32'h0);
        offer(OP_LIST, 3'd4, 32'h0);
        offer(OP_NONE, 3'd0, 32'hFFFF_FFFF);
        offer(OP_NONE, 3'd7, 32'h0);
        for (int i = 0; i < 6; i++) offer(OP_PUSH, 3'd2, (i[0]) ? 32'h5A5A_5A5A : $urandom);
        offer(OP_PUSH, 3'd2, 32'hDEAD_BEEF);
        offer(OP_LIST, 3'd2, 32'h0);
        offer(OP_POP,  3'd1, 32'h0);
        offer(OP_POP,  3'd1, 32'h0);

        foreach (counts[p]) begin
            write_count(counts[p]);
            if (p == 4) holds_asked <= holds_asked + 1;
            fill_and_list(INDEX_W'($urandom_range(0, board.count - 1)));
            if (p == 2) wait_drained();
            random_items(2);
        end
        write_count(4'(COUNT_RESET));
        random_items(10);

        wait_drained();
        repeat (SETTLE) @(posedge aclk);
        $display("Run: %0d input transfers, %0d result transfers, %0d stack_count writes.",
                 board.items_in, board.results_out, count_writes);
        $display("Covered push/pop/list, full, empty, bad index, ignored opcode, stalls.");
        if (board.errors == 0 && board.expected_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
